@@ hw/rtl/tpcba_pkg.sv @@
package tpcba_pkg;

    localparam int RAW_W     = 10;
    localparam int DUTY_W    = 16;
    localparam int VAL_W     = 11;
    localparam int AVG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [VAL_W-1:0] ADC_OFFSET = VAL_W'(20);
    localparam int AVG_MAX = 1023;
    localparam int AVG_MIN = -1024;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTI_PHASE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DUTY_LEVEL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control shared by all three lanes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_clr;
    } lane_ctrl_t;

endpackage

@@ hw/rtl/tpcba_if.sv @@
interface tpcba_in_if
    import tpcba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_a;
    logic [RAW_W-1:0]  raw_b;
    logic [RAW_W-1:0]  raw_c;
    logic              blank_a;
    logic              blank_b;
    logic              blank_c;
    logic              dir_a;
    logic              dir_b;
    logic              dir_c;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;

    modport source (
        output valid, raw_a, raw_b, raw_c, blank_a, blank_b, blank_c,
               dir_a, dir_b, dir_c, duty_a, duty_b, duty_c,
        input  ready
    );
    modport sink (
        input  valid, raw_a, raw_b, raw_c, blank_a, blank_b, blank_c,
               dir_a, dir_b, dir_c, duty_a, duty_b, duty_c,
        output ready
    );
endinterface

interface tpcba_out_if
    import tpcba_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [AVG_W-1:0] avg_a;
    logic signed [AVG_W-1:0] avg_b;
    logic signed [AVG_W-1:0] avg_c;

    modport source (
        output valid, avg_a, avg_b, avg_c,
        input  ready
    );
    modport sink (
        input  valid, avg_a, avg_b, avg_c,
        output ready
    );
endinterface

interface tpcba_cfg_if
    import tpcba_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hw/rtl/tpcba_lane.sv @@
module tpcba_lane
    import tpcba_pkg::*;
#(
    parameter int WINDOW = 8,
    parameter int SLOT_W = $clog2(WINDOW),
    parameter int SUM_W  = VAL_W + $clog2(WINDOW)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctrl_t              ctrl,
    input  logic [SLOT_W-1:0]       wr_slot,
    input  logic [SLOT_W-1:0]       rd_addr,
    input  logic                    anti_phase_mode,
    input  logic [DUTY_W-1:0]       zero_duty_level,
    input  logic [RAW_W-1:0]        raw,
    input  logic                    blank,
    input  logic                    dir,
    input  logic [DUTY_W-1:0]       duty,
    output logic signed [SUM_W-1:0] sum
);

    logic signed [VAL_W-1:0] store [WINDOW];
    logic [WINDOW-1:0]       vld_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;
    logic                    rd_hit_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic signed [VAL_W-1:0] offs;
    logic signed [VAL_W-1:0] val;
    logic                    negate;
    logic                    store_en;

    always_comb
    begin
        offs     = $signed({1'b0, raw} - ADC_OFFSET);
        negate   = anti_phase_mode & (dir ^ (duty < zero_duty_level));
        val      = negate ? -offs : offs;
        store_en = ctrl.wr_en & ~blank;
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store[wr_slot] <= val;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_hit_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            if (store_en)
            begin
                vld_reg[wr_slot] <= 1'b1;
            end
            rd_vld_reg <= ctrl.rd_en;
            if (ctrl.rd_en)
            begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
            if (ctrl.acc_clr)
            begin
                acc_reg <= '0;
            end
            else if (rd_vld_reg && rd_hit_reg)
            begin
                acc_reg <= acc_reg + SUM_W'(rd_data_reg);
            end
        end
    end

    assign sum = acc_reg;

endmodule

@@ hw/rtl/tpcba_merge.sv @@
module tpcba_merge
    import tpcba_pkg::*;
#(
    parameter int WINDOW       = 8,
    parameter int WINDOW_SHIFT = 3,
    parameter int SUM_W        = VAL_W + $clog2(WINDOW)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic signed [SUM_W-1:0] sum_a,
    input  logic signed [SUM_W-1:0] sum_b,
    input  logic signed [SUM_W-1:0] sum_c,
    output logic                    can_load,
    tpcba_out_if.source             averages
);

    localparam logic signed [SUM_W-1:0] SAT_MAX = $signed(SUM_W'(AVG_MAX));
    localparam logic signed [SUM_W-1:0] SAT_MIN = $signed(SUM_W'(AVG_MIN));

    logic                    valid_reg;
    logic signed [AVG_W-1:0] avg_a_reg;
    logic signed [AVG_W-1:0] avg_b_reg;
    logic signed [AVG_W-1:0] avg_c_reg;
    logic signed [AVG_W-1:0] avg_a_next;
    logic signed [AVG_W-1:0] avg_b_next;
    logic signed [AVG_W-1:0] avg_c_next;

    function automatic logic signed [AVG_W-1:0] scale_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        sh = s >>> WINDOW_SHIFT;
        if (sh > SAT_MAX)
        begin
            return AVG_W'(AVG_MAX);
        end
        else if (sh < SAT_MIN)
        begin
            return AVG_W'(AVG_MIN);
        end
        return sh[AVG_W-1:0];
    endfunction

    always_comb
    begin
        avg_a_next = scale_sat(sum_a);
        avg_b_next = scale_sat(sum_b);
        avg_c_next = scale_sat(sum_c);
        can_load   = ~valid_reg | averages.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (averages.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            avg_a_reg <= avg_a_next;
            avg_b_reg <= avg_b_next;
            avg_c_reg <= avg_c_next;
        end
    end

    assign averages.valid = valid_reg;
    assign averages.avg_a = avg_a_reg;
    assign averages.avg_b = avg_b_reg;
    assign averages.avg_c = avg_c_reg;

endmodule

@@ hw/rtl/three_phase_current_block_averager.sv @@
// Channel   Dir  Payload                                   Handshake
// samples   in   raw_*, blank_*, dir_*, duty_* (3 phases)  valid/ready
// averages  out  avg_a, avg_b, avg_c                       valid/ready
// cfg       in   index, data                               valid/ready, always ready
//
// Items are accepted in idle; the item that wraps the window with the loop enabled
// starts a pass in which the three lanes read their stores one entry a cycle
// and accumulate, then a drain state and the load of the output register.
// The final load waits while a previous result is still held in the output register.
// Reset clears control, the write slot and the per-entry valid bits; no clearing pass.
module three_phase_current_block_averager
    import tpcba_pkg::*;
#(
    parameter int WINDOW       = 8,
    parameter int WINDOW_SHIFT = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    tpcba_in_if.sink      samples,
    tpcba_out_if.source   averages,
    tpcba_cfg_if.sink     cfg
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = VAL_W + $clog2(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    state_t state_reg;
    state_t state_next;

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;

    logic              loop_enable_reg;
    logic              anti_phase_mode_reg;
    logic [DUTY_W-1:0] zero_duty_level_reg;

    lane_ctrl_t        ctrl;
    logic              accept;
    logic              load;
    logic              can_load;

    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [SUM_W-1:0] sum_c;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_enable_reg     <= 1'b0;
            anti_phase_mode_reg <= 1'b0;
            zero_duty_level_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LOOP_ENABLE:     loop_enable_reg     <= cfg.data[0];
                CFG_ANTI_PHASE_MODE: anti_phase_mode_reg <= cfg.data[0];
                CFG_ZERO_DUTY_LEVEL: zero_duty_level_reg <= cfg.data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        ctrl          = '0;
        load          = 1'b0;
        samples.ready = 1'b0;
        accept        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                accept        = samples.valid;
                if (accept)
                begin
                    ctrl.wr_en = 1'b1;
                    if (slot_reg == LAST_SLOT)
                    begin
                        slot_next = '0;
                        if (loop_enable_reg)
                        begin
                            ctrl.acc_clr = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_SUM;
                        end
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                ctrl.rd_en = 1'b1;
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // last entry is accumulated at the end of this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tpcba_lane #(.WINDOW(WINDOW), .SLOT_W(SLOT_W), .SUM_W(SUM_W)) u_lane_a (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .wr_slot         (slot_reg),
        .rd_addr         (cnt_reg),
        .anti_phase_mode (anti_phase_mode_reg),
        .zero_duty_level (zero_duty_level_reg),
        .raw             (samples.raw_a),
        .blank           (samples.blank_a),
        .dir             (samples.dir_a),
        .duty            (samples.duty_a),
        .sum             (sum_a)
    );

    tpcba_lane #(.WINDOW(WINDOW), .SLOT_W(SLOT_W), .SUM_W(SUM_W)) u_lane_b (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .wr_slot         (slot_reg),
        .rd_addr         (cnt_reg),
        .anti_phase_mode (anti_phase_mode_reg),
        .zero_duty_level (zero_duty_level_reg),
        .raw             (samples.raw_b),
        .blank           (samples.blank_b),
        .dir             (samples.dir_b),
        .duty            (samples.duty_b),
        .sum             (sum_b)
    );

    tpcba_lane #(.WINDOW(WINDOW), .SLOT_W(SLOT_W), .SUM_W(SUM_W)) u_lane_c (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .wr_slot         (slot_reg),
        .rd_addr         (cnt_reg),
        .anti_phase_mode (anti_phase_mode_reg),
        .zero_duty_level (zero_duty_level_reg),
        .raw             (samples.raw_c),
        .blank           (samples.blank_c),
        .dir             (samples.dir_c),
        .duty            (samples.duty_c),
        .sum             (sum_c)
    );

    tpcba_merge #(.WINDOW(WINDOW), .WINDOW_SHIFT(WINDOW_SHIFT), .SUM_W(SUM_W)) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .sum_a    (sum_a),
        .sum_b    (sum_b),
        .sum_c    (sum_c),
        .can_load (can_load),
        .averages (averages)
    );

endmodule
